>>> design/ctfv_pkg.sv
// shared types and constants of the ctf value evaluator
package ctfv_pkg;

   localparam int TRIG_TABLE_DEPTH_DEF = 1024;
   localparam int SINE_LAT             = 11;
   localparam int FRONT_LAT            = SINE_LAT + 4;
   localparam int PHASE_LAT            = SINE_LAT + 3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WAVELENGTH  = 3'd0,
      CSR_SPH_ABER    = 3'd1,
      CSR_DF_MIN      = 3'd2,
      CSR_DF_MAX      = 3'd3,
      CSR_ASTIG       = 3'd4,
      CSR_AMP_PHASE   = 3'd5,
      CSR_EXTRA_PHASE = 3'd6
   } csr_idx_type;

   localparam logic [30:0] CF_A  = 31'd1686629713;
   localparam logic [30:0] CF_B  = 31'd693598668;
   localparam logic [30:0] CF_C  = 31'd85569306;
   localparam logic [30:0] CF_D  = 31'd5026995;
   localparam logic [30:0] CF_E  = 31'd172271;
   localparam logic [30:0] ONE30 = 31'h4000_0000;

   typedef struct packed {
      logic [31:0]        wavelength;
      logic [31:0]        sph_aber;
      logic [23:0]        df_min;
      logic [23:0]        df_max;
      logic signed [15:0] astig;
      logic [15:0]        amp_phase;
      logic [15:0]        extra_phase;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] ws2;
      logic [31:0] br_mag;
      logic        br_neg;
   } front_type;

   typedef struct packed {
      logic signed [11:0] extrema_count;
      logic signed [15:0] ctf_value;
   } result_type;

endpackage

>>> design/ctf_value_evaluator.sv
// top level of the astigmatic ctf value evaluator
//
//  channel  dir  handshake              beat contents (low bit first)
//  req      in   req_tvalid/req_tready  spatial_freq[15:0], azimuth[31:16]
//  rsp      out  rsp_tvalid/rsp_tready  ctf_value[15:0], extrema_count[27:16]
//  csr      in   csr_wr_en              csr_addr selects register, csr_wr_data
//
//  one beat per cycle sustained unless rsp stalls with the result buffer full; a beat
//  reaches the result buffer through the front and phase pipelines, each with one pass of the 11 stage sine unit
//  a two entry result buffer keeps the pipeline moving while rsp stalls, until it is full
//  reset clears the configuration registers, the valid bits and the result buffer pointers and count
module ctf_value_evaluator #(
   parameter int TRIG_TABLE_DEPTH = ctfv_pkg::TRIG_TABLE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // spatial_freq, azimuth
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // ctf_value, extrema_count
   input  logic                            csr_wr_en,
   input  logic [ctfv_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ctfv_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import ctfv_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   front_type          front;
   logic               en;
   logic               ph_valid;
   logic signed [15:0] ph_value;
   logic signed [11:0] ph_count;
   result_type         buf_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               push, pop;
   result_type         head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_idx_type'(csr_addr))
            CSR_WAVELENGTH:  cfg_in.wavelength  = csr_wr_data;
            CSR_SPH_ABER:    cfg_in.sph_aber    = csr_wr_data;
            CSR_DF_MIN:      cfg_in.df_min      = csr_wr_data[23:0];
            CSR_DF_MAX:      cfg_in.df_max      = csr_wr_data[23:0];
            CSR_ASTIG:       cfg_in.astig       = $signed(csr_wr_data[15:0]);
            CSR_AMP_PHASE:   cfg_in.amp_phase   = csr_wr_data[15:0];
            CSR_EXTRA_PHASE: cfg_in.extra_phase = csr_wr_data[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign en         = !ph_valid || (cnt_ff != 2'd2) || rsp_tready;
   assign req_tready = en;

   ctfv_front #(
      .DEPTH(TRIG_TABLE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_tvalid),
      .spatial_freq($signed(req_tdata[15:0])),
      .azimuth     ($signed(req_tdata[31:16])),
      .cfg         (cfg_ff),
      .front       (front)
   );

   ctfv_phase #(
      .DEPTH(TRIG_TABLE_DEPTH)
   ) u_phase (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .front        (front),
      .cfg          (cfg_ff),
      .out_valid    (ph_valid),
      .ctf_value    (ph_value),
      .extrema_count(ph_count)
   );

   assign push = en && ph_valid;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= '{extrema_count: ph_count, ctf_value: ph_value};
      end
   end

   assign head       = buf_ff[rd_ptr_ff];
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {4'b0, head.extrema_count, head.ctf_value};

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result buffer count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != 2'd2) || pop)
      else $error("result buffer written while full");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("result buffer count did not drop on a read");

endmodule

>>> design/ctfv_sine.sv
// pipelined quantized sine: angle in pi/32768 units to q1.15
module ctfv_sine #(
   parameter int DEPTH = ctfv_pkg::TRIG_TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               en,
   input  logic [15:0]        angle,
   output logic signed [15:0] sine
);
   import ctfv_pkg::*;

   localparam int KW = $clog2(DEPTH) + 1;
   localparam int RW = $clog2(DEPTH);
   localparam int PW = 17 + KW;
   localparam logic [PW-1:0]   DEPTH_P = PW'(DEPTH);
   localparam logic [PW-1:0]   HALF_P  = PW'(32768);
   localparam logic [KW-1:0]   DEPTH_K = KW'(DEPTH);
   localparam logic [RW+1:0]   D1 = (RW+2)'(DEPTH);
   localparam logic [RW+1:0]   D2 = (RW+2)'(2 * DEPTH);
   localparam logic [RW+1:0]   D3 = (RW+2)'(3 * DEPTH);
   localparam logic [44:0]     RECIP = 45'((64'd1 << 44) / 64'(DEPTH));
   localparam logic [47:0]     DEPTH_W = 48'(DEPTH);
   localparam logic [30:0]     HORNER [4] = '{CF_D, CF_C, CF_B, CF_A};

   logic [RW-1:0]   k_ff, k_in;
   logic [1:0]      quad_ff, quad_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [1:0]      quad3_ff;
   logic [RW-1:0]   rem3_ff;
   logic [30:0]     q0_ff, q0_in;
   logic [30:0]     x_ff  [6];
   logic [30:0]     x_in;
   logic            neg_ff [7];
   logic [30:0]     x2_ff [4];
   logic [30:0]     x2_in;
   logic [30:0]     t_ff  [4];
   logic [30:0]     t_in  [4];
   logic [31:0]     r_ff, r_in;
   logic signed [15:0] sine_ff, sine_in;

   // quantize to the nearest point
   always_comb begin
      logic [PW-1:0] kp;
      logic [KW-1:0] k_raw;
      kp    = PW'(angle) * DEPTH_P + HALF_P;
      k_raw = kp[16 +: KW];
      if (k_raw >= DEPTH_K) begin
         k_raw = k_raw - DEPTH_K;
      end
      k_in = RW'(k_raw);
   end

   // quadrant split
   always_comb begin
      logic [RW+1:0] q4;
      q4 = {k_ff, 2'b00};
      if (q4 >= D3) begin
         quad_in = 2'd3;
         rem_in  = RW'(q4 - D3);
      end else if (q4 >= D2) begin
         quad_in = 2'd2;
         rem_in  = RW'(q4 - D2);
      end else if (q4 >= D1) begin
         quad_in = 2'd1;
         rem_in  = RW'(q4 - D1);
      end else begin
         quad_in = 2'd0;
         rem_in  = RW'(q4);
      end
   end

   // reciprocal estimate of rem * 2^30 / depth
   always_comb begin
      logic [RW+44:0] prod;
      prod  = (RW+45)'(rem_ff) * (RW+45)'(RECIP);
      q0_in = prod[14 +: 31];
   end

   // one step correction and quadrant mirror
   always_comb begin
      logic [47:0] lhs;
      logic [47:0] thr;
      logic [30:0] xq;
      lhs = 48'({rem3_ff, 30'b0});
      thr = (48'(q0_ff) + 48'd1) * DEPTH_W;
      xq  = (lhs >= thr) ? q0_ff + 31'd1 : q0_ff;
      x_in = quad3_ff[0] ? ONE30 - xq : xq;
   end

   always_comb begin
      logic [61:0] p;
      p     = 62'(x_ff[0]) * 62'(x_ff[0]);
      x2_in = p[60:30];
   end

   always_comb begin
      logic [61:0] p;
      for (int i = 0; i < 4; i++) begin
         p = 62'(x2_ff[i]) * 62'((i == 0) ? CF_E : t_ff[(i == 0) ? 0 : i - 1]);
         t_in[i] = HORNER[i] - p[60:30];
      end
   end

   always_comb begin
      logic [61:0] p;
      p    = 62'(x_ff[5]) * 62'(t_ff[3]);
      r_in = p[61:30];
   end

   always_comb begin
      logic [32:0] rr;
      logic [14:0] m15;
      rr  = (33'(r_ff) + 33'd16384) >> 15;
      m15 = (rr > 33'd32767) ? 15'h7fff : rr[14:0];
      sine_in = neg_ff[6] ? -$signed({1'b0, m15}) : $signed({1'b0, m15});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_ff     <= k_in;
         quad_ff  <= quad_in;
         rem_ff   <= rem_in;
         quad3_ff <= quad_ff;
         rem3_ff  <= rem_ff;
         q0_ff    <= q0_in;
         x_ff[0]  <= x_in;
         neg_ff[0] <= quad3_ff[1];
         for (int i = 1; i < 6; i++) begin
            x_ff[i] <= x_ff[i-1];
         end
         for (int i = 1; i < 7; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
         x2_ff[0] <= x2_in;
         for (int i = 1; i < 4; i++) begin
            x2_ff[i] <= x2_ff[i-1];
         end
         for (int i = 0; i < 4; i++) begin
            t_ff[i] <= t_in[i];
         end
         r_ff    <= r_in;
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

>>> design/ctfv_front.sv
// defocus along the azimuth and the bracket of the phase polynomial
module ctfv_front #(
   parameter int DEPTH = ctfv_pkg::TRIG_TABLE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [15:0]  spatial_freq,
   input  logic signed [15:0]  azimuth,
   input  ctfv_pkg::cfg_type   cfg,
   output ctfv_pkg::front_type front
);
   import ctfv_pkg::*;

   logic               vld_ff [FRONT_LAT];
   logic [30:0]        s2_ff, s2_in;
   logic [15:0]        cang_ff, cang_in;
   logic [31:0]        ws2_ff [SINE_LAT];
   logic [31:0]        ws2_in;
   logic [31:0]        w2s2_ff, w2s2_in;
   logic [34:0]        half_ff [SINE_LAT-2];
   logic [34:0]        half_in;
   logic signed [15:0] cos_val;
   logic signed [40:0] prod_ff, prod_in;
   logic [31:0]        ws2_13_ff, ws2_14_ff;
   logic [34:0]        half_13_ff, half_14_ff;
   logic signed [25:0] d_ff, d_in;
   logic [31:0]        ws2_15_ff;
   logic [31:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;

   always_comb begin
      logic signed [31:0] sq;
      logic [15:0]        da;
      sq      = spatial_freq * spatial_freq;
      s2_in   = sq[30:0];
      da      = azimuth - cfg.astig;
      cang_in = {da[14:0], 1'b0} + 16'h4000;
   end

   always_comb begin
      logic [62:0] p;
      p      = 63'(cfg.wavelength) * 63'(s2_ff);
      ws2_in = p[61:30];
   end

   always_comb begin
      logic [63:0] p;
      p       = 64'(cfg.wavelength) * 64'(ws2_ff[0]);
      w2s2_in = p[63:32];
   end

   always_comb begin
      logic [63:0] p;
      p       = 64'(w2s2_ff) * 64'(cfg.sph_aber);
      half_in = p[63:29];
   end

   ctfv_sine #(
      .DEPTH(DEPTH)
   ) u_cos (
      .clock(clock),
      .en   (en),
      .angle(cang_ff),
      .sine (cos_val)
   );

   always_comb begin
      logic signed [24:0] dif;
      dif     = $signed({1'b0, cfg.df_max}) - $signed({1'b0, cfg.df_min});
      prod_in = dif * cos_val;
   end

   always_comb begin
      logic [24:0]        sum;
      logic signed [41:0] tot;
      sum  = 25'(cfg.df_max) + 25'(cfg.df_min);
      tot  = $signed({2'b0, sum, 15'b0}) + 42'(prod_ff) + 42'sd32768;
      d_in = tot[41:16];
   end

   // bracket with lower clamp, split into sign and magnitude
   always_comb begin
      logic signed [36:0] br;
      br = 37'(d_ff) - $signed({2'b0, half_14_ff});
      if (br < -37'sd2147483648) begin
         br = -37'sd2147483648;
      end
      neg_in = br[36];
      mag_in = neg_in ? 32'(-br) : 32'(br);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRONT_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < FRONT_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff     <= s2_in;
         cang_ff   <= cang_in;
         ws2_ff[0] <= ws2_in;
         for (int i = 1; i < SINE_LAT; i++) begin
            ws2_ff[i] <= ws2_ff[i-1];
         end
         w2s2_ff    <= w2s2_in;
         half_ff[0] <= half_in;
         for (int i = 1; i < SINE_LAT - 2; i++) begin
            half_ff[i] <= half_ff[i-1];
         end
         prod_ff    <= prod_in;
         ws2_13_ff  <= ws2_ff[SINE_LAT-1];
         half_13_ff <= half_ff[SINE_LAT-3];
         d_ff       <= d_in;
         ws2_14_ff  <= ws2_13_ff;
         half_14_ff <= half_13_ff;
         ws2_15_ff  <= ws2_14_ff;
         mag_ff     <= mag_in;
         neg_ff     <= neg_in;
      end
   end

   assign front.valid  = vld_ff[FRONT_LAT-1];
   assign front.ws2    = ws2_15_ff;
   assign front.br_mag = mag_ff;
   assign front.br_neg = neg_ff;

endmodule

>>> design/ctfv_phase.sv
// phase, its sine and the extremum count
module ctfv_phase #(
   parameter int DEPTH = ctfv_pkg::TRIG_TABLE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  ctfv_pkg::front_type front,
   input  ctfv_pkg::cfg_type   cfg,
   output logic                out_valid,
   output logic signed [15:0]  ctf_value,
   output logic signed [11:0]  extrema_count
);
   import ctfv_pkg::*;

   logic               vld_ff [PHASE_LAT];
   logic [63:0]        mag_ff, mag_in;
   logic               neg1_ff, neg2_ff;
   logic [39:0]        m_ff, m_in;
   logic signed [41:0] p_ff, p_in;
   logic [42:0]        vmag_ff, vmag_in;
   logic               vneg_ff, vneg_in;
   logic signed [11:0] cnt_ff [SINE_LAT-1];
   logic signed [11:0] cnt_in;
   logic signed [15:0] sine_val;

   assign mag_in = 64'(front.ws2) * 64'(front.br_mag);

   // floor of the signed product over 2^25
   always_comb begin
      logic [64:0] a;
      a    = neg1_ff ? 65'(mag_ff) + 65'h1ff_ffff : 65'(mag_ff);
      m_in = a[64:25];
   end

   always_comb begin
      logic signed [41:0] sm;
      sm   = neg2_ff ? -$signed({2'b0, m_ff}) : $signed({2'b0, m_ff});
      p_in = sm + $signed({26'b0, cfg.amp_phase}) + $signed({26'b0, cfg.extra_phase});
   end

   always_comb begin
      logic signed [42:0] v;
      v       = 43'(p_ff) + 43'sd16384;
      vneg_in = v[42];
      vmag_in = vneg_in ? 43'(-v) : 43'(v);
   end

   always_comb begin
      logic [27:0] c;
      c = vmag_ff[42:15];
      if (!vneg_ff) begin
         cnt_in = (c > 28'd2047) ? 12'sd2047 : $signed(c[11:0]);
      end else begin
         cnt_in = (c > 28'd2048) ? -12'sd2048 : -$signed(c[11:0]);
      end
   end

   ctfv_sine #(
      .DEPTH(DEPTH)
   ) u_sin (
      .clock(clock),
      .en   (en),
      .angle(p_ff[15:0]),
      .sine (sine_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PHASE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= front.valid;
         for (int i = 1; i < PHASE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff    <= mag_in;
         neg1_ff   <= front.br_neg;
         m_ff      <= m_in;
         neg2_ff   <= neg1_ff;
         p_ff      <= p_in;
         vmag_ff   <= vmag_in;
         vneg_ff   <= vneg_in;
         cnt_ff[0] <= cnt_in;
         for (int i = 1; i < SINE_LAT - 1; i++) begin
            cnt_ff[i] <= cnt_ff[i-1];
         end
      end
   end

   assign out_valid     = vld_ff[PHASE_LAT-1];
   assign ctf_value     = -sine_val;
   assign extrema_count = cnt_ff[SINE_LAT-2];

endmodule
